### src/pscba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two size-class allocator package
// Shared field widths, codes, item types and controller states.
// ----------------------------------------------------------------------------
package pscba_pkg;

    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 27;
    localparam int CLASS_W     = 5;
    localparam int PAGES_CFG_W = 7;
    localparam int CFG_W       = 48;
    localparam int HDR_BYTES   = 8;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_EXHAUSTED = 2'd2,
        STATUS_BAD_FREE  = 2'd3
    } status_t;

    localparam logic CFG_POOL_BASE    = 1'b0;
    localparam logic CFG_PAGES_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SWEEP
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   user_address;
        logic [SIZE_W-1:0]   avail_size;
        status_t             status;
    } rsp_t;

endpackage

### src/pow2_size_class_buffer_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two size-class buffer allocator
// Segregated LIFO free lists over a bump-claimed page pool.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// rsp for exactly one cycle with done high and cannot be held off. An
// allocate that pops a free list goes through decode, link memory read and
// pop before its result, since the successor comes from the link memory,
// whose read data is registered. Every other item reports from the execute
// state: the free path reads the page class table in the accept cycle and
// decides in the next. An allocate that claims a buffer spanning n pages
// keeps busy high after it reports, while the n - 1 continuation pages
// are marked in the page class table, one per cycle.
// Configuration writes are taken at any time through cfg_we and must only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
module pow2_size_class_buffer_allocator #(
    parameter int PAGE_SHIFT      = 16,
    parameter int POOL_PAGES      = 64,
    parameter int MIN_CLASS_SHIFT = 5,
    parameter int MAX_CLASS_SHIFT = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pscba_pkg::req_t               req,
    output logic                          done,
    output pscba_pkg::rsp_t               rsp,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pscba_pkg::CFG_W-1:0]   cfg_data
);

    // Slots are 2^MIN_CLASS_SHIFT byte units; a slot index is page and offset.
    localparam int NUM_CLASSES = MAX_CLASS_SHIFT - MIN_CLASS_SHIFT + 1;
    localparam int CLS_IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SPS         = PAGE_SHIFT - MIN_CLASS_SHIFT;
    localparam int PAGE_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int SLOT_W      = PAGE_W + SPS;
    localparam int NFP_W       = $clog2(POOL_PAGES + 1);
    localparam int CL_W        = SPS + 1;
    localparam int NPG_W       = ((MAX_CLASS_SHIFT > PAGE_SHIFT)
                                  ? (MAX_CLASS_SHIFT - PAGE_SHIFT) : 0) + 1;
    localparam int SUM_A       = (NPG_W > NFP_W) ? NPG_W : NFP_W;
    localparam int SUM_W       = ((SUM_A > pscba_pkg::PAGES_CFG_W)
                                  ? SUM_A : pscba_pkg::PAGES_CFG_W) + 1;
    localparam int AW          = pscba_pkg::ADDR_W;
    localparam int HI_W        = AW - PAGE_SHIFT;
    localparam int CW          = pscba_pkg::CLASS_W;

    pscba_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                       pool_base_reg;
    logic [pscba_pkg::PAGES_CFG_W-1:0]   pages_in_use_reg;
    pscba_pkg::req_t                     req_reg;
    logic [AW-1:0]                       off_reg, off_next;
    logic                                page_ok_reg, page_ok_next;
    logic [NFP_W-1:0]                    nfp_reg, nfp_next;
    logic [SLOT_W-1:0]                   free_head_reg [NUM_CLASSES];
    logic                                head_valid_reg [NUM_CLASSES];
    logic [SLOT_W-1:0]                   carve_next_reg [NUM_CLASSES];
    logic [CL_W-1:0]                     carve_left_reg [NUM_CLASSES];
    logic [PAGE_W-1:0]                   sweep_ptr_reg, sweep_ptr_next;
    logic [PAGE_W-1:0]                   sweep_end_reg, sweep_end_next;
    logic                                done_reg, done_next;
    pscba_pkg::rsp_t                     rsp_reg, rsp_next;

    // Per-class table update, applied at one class index.
    logic                                cls_we;
    logic [CLS_IDX_W-1:0]                cls_idx;
    logic                                hv_wdata;
    logic [SLOT_W-1:0]                   head_wdata;
    logic                                head_we;
    logic [SLOT_W-1:0]                   cn_wdata;
    logic                                cn_we;
    logic [CL_W-1:0]                     cl_wdata;
    logic                                cl_we;

    logic [CW-1:0]                       alloc_class;
    logic [CLS_IDX_W-1:0]                ac;
    logic [CW-1:0]                       pg_rdata;
    logic [CLS_IDX_W-1:0]                fc;
    logic [SLOT_W-1:0]                   link_rdata;
    logic                                link_we;
    logic [SLOT_W-1:0]                   link_waddr, link_wdata, link_raddr;
    logic                                pg_we;
    logic [PAGE_W-1:0]                   pg_waddr, pg_raddr;
    logic [CW-1:0]                       pg_wdata;

    logic                                accept;
    logic [AW-1:0]                       off_in;
    logic [HI_W-1:0]                     page_hi_in;

    logic [SUM_W-1:0]                    limit;
    logic [SUM_W-1:0]                    npages;
    logic [PAGE_W-1:0]                   cur_page;
    logic                                go_pop, go_sweep;
    logic [SLOT_W-1:0]                   alloc_slot;
    logic                                alloc_ok;
    logic [SLOT_W-1:0]                   free_slot;
    logic [CW-1:0]                       align;
    logic [PAGE_SHIFT-1:0]               align_mask;
    logic [SLOT_W-1:0]                   step;

    assign accept = start && (state_reg == pscba_pkg::S_IDLE);
    assign busy   = (state_reg != pscba_pkg::S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // Header address offset from the pool base, and its page.
    assign off_in     = req.free_address - AW'(pscba_pkg::HDR_BYTES) - pool_base_reg;
    assign page_hi_in = off_in[AW-1:PAGE_SHIFT];
    assign pg_raddr   = off_in[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];

    pscba_class_enc #(
        .MIN_CLASS_SHIFT (MIN_CLASS_SHIFT)
    ) u_class_enc (
        .request_size (req_reg.request_size),
        .size_class   (alloc_class)
    );

    pscba_link_mem #(
        .SLOT_W (SLOT_W)
    ) u_link_mem (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    pscba_page_mem #(
        .PAGE_W (PAGE_W)
    ) u_page_mem (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    assign ac       = CLS_IDX_W'(alloc_class - CW'(MIN_CLASS_SHIFT));
    assign fc       = CLS_IDX_W'(pg_rdata - CW'(MIN_CLASS_SHIFT));
    assign cur_page = nfp_reg[PAGE_W-1:0];
    assign limit    = (SUM_W'(pages_in_use_reg) < SUM_W'(POOL_PAGES))
                    ? SUM_W'(pages_in_use_reg) : SUM_W'(POOL_PAGES);
    assign npages   = SUM_W'(NPG_W'(1) << NPG_W'(alloc_class - CW'(PAGE_SHIFT)));
    assign step     = SLOT_W'(1) << ac;
    assign free_slot = off_reg[SLOT_W+MIN_CLASS_SHIFT-1:MIN_CLASS_SHIFT];
    assign align    = (pg_rdata < CW'(PAGE_SHIFT)) ? pg_rdata : CW'(PAGE_SHIFT);
    assign align_mask = (PAGE_SHIFT'(1) << align) - PAGE_SHIFT'(1);

    // Branch flags of the execute cycle, used by the next-state block.
    always_comb
    begin
        go_pop   = 1'b0;
        go_sweep = 1'b0;
        if (req_reg.command == pscba_pkg::CMD_ALLOC)
        begin
            if (alloc_class <= CW'(MAX_CLASS_SHIFT))
            begin
                if (head_valid_reg[ac])
                begin
                    go_pop = 1'b1;
                end
                else if (carve_left_reg[ac] == '0 && alloc_class > CW'(PAGE_SHIFT) &&
                         SUM_W'(nfp_reg) + npages <= limit && npages > SUM_W'(1))
                begin
                    go_sweep = 1'b1;
                end
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pscba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = pscba_pkg::S_EXEC;
                end
            end
            pscba_pkg::S_EXEC:
            begin
                if (go_pop)
                begin
                    state_next = pscba_pkg::S_POP;
                end
                else if (go_sweep)
                begin
                    state_next = pscba_pkg::S_SWEEP;
                end
                else
                begin
                    state_next = pscba_pkg::S_IDLE;
                end
            end
            pscba_pkg::S_POP:
            begin
                state_next = pscba_pkg::S_IDLE;
            end
            pscba_pkg::S_SWEEP:
            begin
                if (sweep_ptr_reg == sweep_end_reg)
                begin
                    state_next = pscba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pscba_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        off_next       = off_reg;
        page_ok_next   = page_ok_reg;
        nfp_next       = nfp_reg;
        sweep_ptr_next = sweep_ptr_reg;
        sweep_end_next = sweep_end_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        cls_we         = 1'b0;
        cls_idx        = ac;
        hv_wdata       = 1'b0;
        head_we        = 1'b0;
        head_wdata     = '0;
        cn_we          = 1'b0;
        cn_wdata       = '0;
        cl_we          = 1'b0;
        cl_wdata       = '0;
        link_we        = 1'b0;
        link_waddr     = free_slot;
        link_wdata     = free_slot;
        link_raddr     = free_head_reg[ac];
        pg_we          = 1'b0;
        pg_waddr       = cur_page;
        pg_wdata       = alloc_class;
        alloc_slot     = '0;
        alloc_ok       = 1'b0;

        unique case (state_reg)
            pscba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    off_next     = off_in;
                    page_ok_next = (page_hi_in < HI_W'(nfp_reg)) &&
                                   (page_hi_in < HI_W'(POOL_PAGES));
                end
            end
            pscba_pkg::S_EXEC:
            begin
                done_next = 1'b1;
                rsp_next  = '{user_address: '0, avail_size: '0,
                              status: pscba_pkg::STATUS_OK};
                if (req_reg.command == pscba_pkg::CMD_ALLOC)
                begin
                    priority if (alloc_class > CW'(MAX_CLASS_SHIFT))
                    begin
                        rsp_next.status = pscba_pkg::STATUS_TOO_LARGE;
                    end
                    else if (head_valid_reg[ac])
                    begin
                        // Result comes from the pop once the link is read.
                        done_next = 1'b0;
                    end
                    else if (carve_left_reg[ac] != '0)
                    begin
                        alloc_slot = carve_next_reg[ac];
                        alloc_ok   = 1'b1;
                        cls_we     = 1'b1;
                        cl_we      = 1'b1;
                        cl_wdata   = carve_left_reg[ac] - CL_W'(1);
                        cn_we      = (cl_wdata != '0);
                        cn_wdata   = alloc_slot - step;
                    end
                    else if (alloc_class <= CW'(PAGE_SHIFT))
                    begin
                        if (SUM_W'(nfp_reg) + SUM_W'(1) > limit)
                        begin
                            rsp_next.status = pscba_pkg::STATUS_EXHAUSTED;
                        end
                        else
                        begin
                            // Carve a fresh page from its top buffer down.
                            nfp_next   = nfp_reg + NFP_W'(1);
                            pg_we      = 1'b1;
                            alloc_slot = (SLOT_W'(cur_page) << SPS) +
                                         (SLOT_W'(1) << SPS) - step;
                            alloc_ok   = 1'b1;
                            cls_we     = 1'b1;
                            cl_we      = 1'b1;
                            cl_wdata   = (CL_W'(1) << CL_W'(SPS - int'(ac)))
                                       - CL_W'(1);
                            cn_we      = (cl_wdata != '0);
                            cn_wdata   = alloc_slot - step;
                        end
                    end
                    else
                    begin
                        if (SUM_W'(nfp_reg) + npages > limit)
                        begin
                            rsp_next.status = pscba_pkg::STATUS_EXHAUSTED;
                        end
                        else
                        begin
                            nfp_next       = NFP_W'(SUM_W'(nfp_reg) + npages);
                            pg_we          = 1'b1;
                            alloc_slot     = SLOT_W'(cur_page) << SPS;
                            alloc_ok       = 1'b1;
                            sweep_ptr_next = cur_page + PAGE_W'(1);
                            sweep_end_next = PAGE_W'(SUM_W'(nfp_reg) + npages - SUM_W'(1));
                        end
                    end
                end
                else
                begin
                    priority if (!page_ok_reg ||
                                 pg_rdata < CW'(MIN_CLASS_SHIFT) ||
                                 pg_rdata > CW'(MAX_CLASS_SHIFT) ||
                                 (off_reg[PAGE_SHIFT-1:0] & align_mask) != '0)
                    begin
                        rsp_next.status = pscba_pkg::STATUS_BAD_FREE;
                    end
                    else if (carve_left_reg[fc] != '0 &&
                             carve_next_reg[fc][SLOT_W-1:SPS] ==
                             off_reg[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT] &&
                             free_slot <= carve_next_reg[fc])
                    begin
                        // Buffer not carved yet.
                        rsp_next.status = pscba_pkg::STATUS_BAD_FREE;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_wdata = head_valid_reg[fc] ? free_head_reg[fc] : free_slot;
                        cls_idx    = fc;
                        cls_we     = 1'b1;
                        hv_wdata   = 1'b1;
                        head_we    = 1'b1;
                        head_wdata = free_slot;
                    end
                end
            end
            pscba_pkg::S_POP:
            begin
                alloc_slot = free_head_reg[ac];
                alloc_ok   = 1'b1;
                done_next  = 1'b1;
                cls_we     = 1'b1;
                // A slot linked to itself is the list's last entry.
                if (link_rdata == alloc_slot)
                begin
                    hv_wdata = 1'b0;
                end
                else
                begin
                    hv_wdata   = 1'b1;
                    head_we    = 1'b1;
                    head_wdata = link_rdata;
                end
            end
            pscba_pkg::S_SWEEP:
            begin
                pg_we          = 1'b1;
                pg_waddr       = sweep_ptr_reg;
                pg_wdata       = '0;
                sweep_ptr_next = sweep_ptr_reg + PAGE_W'(1);
            end
            default:
            begin
            end
        endcase

        if (alloc_ok)
        begin
            rsp_next.user_address = pool_base_reg +
                                    (AW'(alloc_slot) << MIN_CLASS_SHIFT) +
                                    AW'(pscba_pkg::HDR_BYTES);
            rsp_next.avail_size   = pscba_pkg::SIZE_W'(
                                    ((pscba_pkg::SIZE_W + 1)'(1) << alloc_class) -
                                    (pscba_pkg::SIZE_W + 1)'(pscba_pkg::HDR_BYTES));
            rsp_next.status       = pscba_pkg::STATUS_OK;
        end
    end

    // Control state and per-class flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pscba_pkg::S_IDLE;
            pool_base_reg    <= '0;
            pages_in_use_reg <= pscba_pkg::PAGES_CFG_W'(64);
            nfp_reg          <= '0;
            done_reg         <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_valid_reg[i] <= 1'b0;
                carve_left_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            nfp_reg   <= nfp_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                if (cfg_index == pscba_pkg::CFG_POOL_BASE)
                begin
                    pool_base_reg <= cfg_data[AW-1:0];
                end
                else
                begin
                    pages_in_use_reg <= cfg_data[pscba_pkg::PAGES_CFG_W-1:0];
                end
            end
            if (cls_we && (head_we || state_reg == pscba_pkg::S_POP))
            begin
                head_valid_reg[cls_idx] <= hv_wdata;
            end
            if (cls_we && cl_we)
            begin
                carve_left_reg[cls_idx] <= cl_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        off_reg       <= off_next;
        page_ok_reg   <= page_ok_next;
        sweep_ptr_reg <= sweep_ptr_next;
        sweep_end_reg <= sweep_end_next;
        rsp_reg       <= rsp_next;
        if (cls_we && head_we)
        begin
            free_head_reg[cls_idx] <= head_wdata;
        end
        if (cls_we && cn_we)
        begin
            carve_next_reg[cls_idx] <= cn_wdata;
        end
    end

endmodule

### src/pscba_class_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class encoder
// Maps a request size to max(MIN_CLASS_SHIFT, ceil(log2(size + header))).
// ----------------------------------------------------------------------------
module pscba_class_enc #(
    parameter int MIN_CLASS_SHIFT = 5
) (
    input  logic [pscba_pkg::SIZE_W-1:0]  request_size,
    output logic [pscba_pkg::CLASS_W-1:0] size_class
);

    logic [pscba_pkg::SIZE_W:0]    total_m1;
    logic [pscba_pkg::CLASS_W-1:0] bit_len;

    // The ceiling of log2(t) is the bit length of t - 1.
    always_comb
    begin
        total_m1 = {1'b0, request_size} + (pscba_pkg::SIZE_W + 1)'(pscba_pkg::HDR_BYTES - 1);
        bit_len  = '0;
        for (int i = 0; i <= pscba_pkg::SIZE_W; i++)
        begin
            if (total_m1[i])
            begin
                bit_len = pscba_pkg::CLASS_W'(i + 1);
            end
        end
        size_class = (bit_len < pscba_pkg::CLASS_W'(MIN_CLASS_SHIFT))
                   ? pscba_pkg::CLASS_W'(MIN_CLASS_SHIFT) : bit_len;
    end

endmodule

### src/pscba_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list link memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pscba_link_mem #(
    parameter int SLOT_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [SLOT_W-1:0] wdata,
    input  logic [SLOT_W-1:0] raddr,
    output logic [SLOT_W-1:0] rdata
);

    logic [SLOT_W-1:0] mem [2**SLOT_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/pscba_page_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page class table
// Holds the size class of each claimed page, zero on continuation pages.
// ----------------------------------------------------------------------------
module pscba_page_mem #(
    parameter int PAGE_W = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [PAGE_W-1:0]             waddr,
    input  logic [pscba_pkg::CLASS_W-1:0] wdata,
    input  logic [PAGE_W-1:0]             raddr,
    output logic [pscba_pkg::CLASS_W-1:0] rdata
);

    logic [pscba_pkg::CLASS_W-1:0] mem [2**PAGE_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two size-class allocator testbench
// Runs a directed table and then random allocate and free items through the
// command port. Every result is checked field by field against the table or an
// in-bench allocator model; the random items run under several pool base and page limit settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int   ADDR_W      = pscba_pkg::ADDR_W;
    localparam int   SIZE_W      = pscba_pkg::SIZE_W;
    localparam int   CFG_W       = pscba_pkg::CFG_W;
    localparam int   PAGES_CFG_W = pscba_pkg::PAGES_CFG_W;
    localparam int   HDR_BYTES   = pscba_pkg::HDR_BYTES;
    localparam int   PAGE_SH     = 16;
    localparam int   MIN_SH      = 5;
    localparam int   MAX_SH      = 22;
    localparam int   NPAGES      = 64;
    localparam int   NCLASS      = MAX_SH - MIN_SH + 1;
    localparam int   SLOT_SH     = PAGE_SH - MIN_SH;
    localparam int   NSLOTS      = NPAGES << SLOT_SH;
    // A multi-page claim keeps the block busy while it marks its continuation pages.
    localparam int   SETTLE      = 100;
    localparam int   N_RANDOM    = 1600;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    pscba_pkg::req_t  req;
    logic             done;
    pscba_pkg::rsp_t  rsp;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pow2_size_class_buffer_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Allocator model state. It mirrors the free lists, the carving
    // cursors, the page bump counter and the per-page class table.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]      pool_base;
    logic [PAGES_CFG_W-1:0] page_cfg;
    logic [16:0]            list_head  [NCLASS];
    logic                   list_valid [NCLASS];
    logic [16:0]            carve_slot [NCLASS];
    logic [11:0]            carve_cnt  [NCLASS];
    logic [6:0]             next_page;
    logic [4:0]             page_cls   [NPAGES];
    logic [16:0]            successor  [NSLOTS];

    pscba_pkg::rsp_t        pending_rsp[$];
    // Header-relative offsets of buffers currently handed out.
    logic [ADDR_W-1:0]      live_off[$];
    int                     errors;

    always #10 clk = ~clk;

    // The final-message logic and the timeout both live in initial blocks;
    // this one bounds the run far above the slowest legal schedule.
    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int page_limit();
        return (page_cfg < NPAGES) ? int'(page_cfg) : NPAGES;
    endfunction

    // Works out the answer to an allocate and updates the model state.
    function automatic pscba_pkg::rsp_t predict_alloc(input logic [SIZE_W-1:0] size);
        logic [63:0]     total;
        logic [16:0]     slot;
        int              b;
        int              c;
        int              p;
        int              cnt;
        pscba_pkg::rsp_t r;
        r = '0;
        r.status = pscba_pkg::STATUS_OK;
        total = 64'(size) + 64'(HDR_BYTES);
        b = MIN_SH;
        while (b < 40 && (64'd1 << b) < total)
            b++;
        if (b > MAX_SH)
        begin
            r.status = pscba_pkg::STATUS_TOO_LARGE;
            return r;
        end
        c = b - MIN_SH;
        p = int'(next_page);
        if (list_valid[c])
        begin
            slot = list_head[c];
            if (successor[slot] == slot)
                list_valid[c] = 1'b0;
            else
                list_head[c] = successor[slot];
        end
        else if (carve_cnt[c] != 0)
        begin
            slot = carve_slot[c];
            carve_cnt[c]--;
            if (carve_cnt[c] != 0)
                carve_slot[c] = slot - (17'd1 << c);
        end
        else if (b <= PAGE_SH)
        begin
            cnt = 1 << (PAGE_SH - b);
            if (p + 1 > page_limit())
            begin
                r.status = pscba_pkg::STATUS_EXHAUSTED;
                return r;
            end
            next_page = 7'(p + 1);
            page_cls[p] = 5'(b);
            slot = 17'((p << SLOT_SH) + (cnt - 1) * (1 << c));
            carve_cnt[c] = 12'(cnt - 1);
            if (cnt > 1)
                carve_slot[c] = slot - (17'd1 << c);
        end
        else
        begin
            cnt = 1 << (b - PAGE_SH);
            if (p + cnt > page_limit())
            begin
                r.status = pscba_pkg::STATUS_EXHAUSTED;
                return r;
            end
            next_page = 7'(p + cnt);
            page_cls[p] = 5'(b);
            for (int i = 1; i < cnt; i++)
                page_cls[p + i] = 5'd0;
            slot = 17'(p << SLOT_SH);
        end
        r.user_address = pool_base + (ADDR_W'(slot) << MIN_SH) + ADDR_W'(HDR_BYTES);
        r.avail_size   = SIZE_W'((64'd1 << b) - 64'(HDR_BYTES));
        return r;
    endfunction

    // Works out the answer to a free and pushes the buffer when it is valid.
    function automatic pscba_pkg::rsp_t predict_free(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] pg;
        logic [16:0]       slot;
        int                b;
        int                c;
        int                align;
        pscba_pkg::rsp_t   r;
        r = '0;
        r.status = pscba_pkg::STATUS_BAD_FREE;
        off = addr - ADDR_W'(HDR_BYTES) - pool_base;
        pg  = off >> PAGE_SH;
        if (pg >= ADDR_W'(next_page) || pg >= ADDR_W'(NPAGES))
            return r;
        b = int'(page_cls[pg]);
        // Class zero marks a continuation page of a multi-page buffer.
        if (b < MIN_SH || b > MAX_SH)
            return r;
        align = (b < PAGE_SH) ? b : PAGE_SH;
        if ((off & ((ADDR_W'(1) << align) - ADDR_W'(1))) != '0)
            return r;
        c = b - MIN_SH;
        slot = 17'(off >> MIN_SH);
        // Buffers of the page that is still being carved are not yet out.
        if (carve_cnt[c] != 0 && (carve_slot[c] >> SLOT_SH) == 17'(pg) &&
            slot <= carve_slot[c])
            return r;
        successor[slot] = list_valid[c] ? list_head[c] : slot;
        list_head[c]  = slot;
        list_valid[c] = 1'b1;
        r.status = pscba_pkg::STATUS_OK;
        return r;
    endfunction

    // Results are sampled at the rising edge that ends their cycle.
    always @(posedge clk)
    begin
        pscba_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report($sformatf("result with nothing pending: addr %h size %0d st %0d",
                                 rsp.user_address, rsp.avail_size, rsp.status));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.user_address !== want.user_address)
                    report($sformatf("user_address %h, want %h",
                                     rsp.user_address, want.user_address));
                if (rsp.avail_size !== want.avail_size)
                    report($sformatf("avail_size %0d, want %0d",
                                     rsp.avail_size, want.avail_size));
                if (rsp.status !== want.status)
                    report($sformatf("status %0d, want %0d", rsp.status, want.status));
            end
        end
    end

    // Issues one item after a gap. Start stays high across back-to-back
    // items, so it is only lowered on cycles that carry no item.
    task automatic issue(input pscba_pkg::req_t r, input int gap, input bit typed,
                         input pscba_pkg::rsp_t want);
        pscba_pkg::rsp_t got;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        while (busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        // Busy seen low at the falling edge holds to the next rising edge,
        // where the item is taken, so the model steps here.
        if (r.command == pscba_pkg::CMD_ALLOC)
            got = predict_alloc(r.request_size);
        else
            got = predict_free(r.free_address);
        pending_rsp.insert(pending_rsp.size(), typed ? want : got);
        if (!typed && r.command == pscba_pkg::CMD_ALLOC && got.status == pscba_pkg::STATUS_OK)
            live_off.insert(live_off.size(), got.user_address - pool_base);
        start <= 1'b1;
        req   <= r;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == pscba_pkg::CFG_POOL_BASE)
            pool_base = val[ADDR_W-1:0];
        else
            page_cfg = val[PAGES_CFG_W-1:0];
        @(negedge clk);
    endtask

    typedef struct {
        pscba_pkg::cmd_t   cmd;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        pscba_pkg::rsp_t   want;
    } row_t;

    function automatic row_t mk(input pscba_pkg::cmd_t cmd, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr, input bit typed,
                                input logic [ADDR_W-1:0] wa, input logic [SIZE_W-1:0] ws,
                                input pscba_pkg::status_t st);
        row_t w;
        w.cmd   = cmd;
        w.size  = size;
        w.addr  = addr;
        w.typed = typed;
        w.want  = '{user_address: wa, avail_size: ws, status: st};
        return w;
    endfunction

    function automatic int draw_gap(input bit bursty);
        return bursty ? 0 : $urandom_range(0, 16);
    endfunction

    initial
    begin
        row_t                   plan[$];
        pscba_pkg::req_t        r;
        pscba_pkg::rsp_t        none;
        int                     pick;
        int                     roll;
        int                     gap;
        bit                     bursty;
        logic [ADDR_W-1:0]      bases [4];
        logic [PAGES_CFG_W-1:0] limits [4];

        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = pscba_pkg::CFG_POOL_BASE;
        cfg_data  = '0;
        errors    = 0;
        none      = '0;

        pool_base = '0;
        page_cfg  = 7'd64;
        next_page = '0;
        for (int i = 0; i < NCLASS; i++)
        begin
            list_head[i]  = '0;
            list_valid[i] = 1'b0;
            carve_slot[i] = '0;
            carve_cnt[i]  = '0;
        end
        for (int i = 0; i < NPAGES; i++)
            page_cls[i] = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset configuration. Pages fill up as
        // 0: class 5, 1: class 6, 2: class 16, 3-4: one class 17 buffer.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 0, 0, 1, 48'd65512, 24,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 24, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 25, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd134217720, 0, 1, 0, 0,
                                    pscba_pkg::STATUS_TOO_LARGE));
        // The largest class needs all 64 pages, and two are already claimed.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd4194296, 0, 1, 0, 0,
                                    pscba_pkg::STATUS_EXHAUSTED));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd4194297, 0, 1, 0, 0,
                                    pscba_pkg::STATUS_TOO_LARGE));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd65528, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd131064, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        // Continuation page of the two-page buffer.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 27'h7FFFFFF, 48'd262152, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        // Zero wraps below the pool when the header is taken off.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd0, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'hFFFF_FFFF_FFFF, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd65512, 1, 0, 0,
                                    pscba_pkg::STATUS_OK));
        // Double free is taken without complaint.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd65512, 1, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 0, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd65516, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        // Slot 0 of page 0 has not been carved yet.
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd8, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd3276808, 1, 0, 0,
                                    pscba_pkg::STATUS_BAD_FREE));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_FREE, 0, 48'd196616, 1, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd131064, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));
        plan.insert(plan.size(), mk(pscba_pkg::CMD_ALLOC, 27'd65528, 0, 0, 0, 0,
                                    pscba_pkg::STATUS_OK));

        foreach (plan[i])
        begin
            r.command      = plan[i].cmd;
            r.request_size = plan[i].size;
            r.free_address = plan[i].addr;
            issue(r, i % 3, plan[i].typed, plan[i].want);
        end
        drain();

        // Random part: four settings, the extremes among them. A page
        // limit above the pool size is clamped to the pool.
        bases[0]  = 48'hFFFF_FFFF_FFFF;                   limits[0] = 7'd1;
        bases[1]  = ADDR_W'({$urandom, $urandom});        limits[1] = 7'd20;
        bases[2]  = 48'd0;                                limits[2] = 7'd127;
        bases[3]  = ADDR_W'({$urandom, $urandom});        limits[3] = 7'd64;

        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(pscba_pkg::CFG_POOL_BASE, CFG_W'(bases[ph]));
            write_cfg(pscba_pkg::CFG_PAGES_IN_USE, CFG_W'(limits[ph]));
            bursty = 1'b0;
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                if ($urandom_range(0, 31) == 0)
                    bursty = ~bursty;
                // Halfway through each setting the sender waits for every result.
                if (n == N_RANDOM / 8)
                    drain();
                gap  = draw_gap(bursty);
                roll = $urandom_range(0, 99);
                r = '0;
                r.free_address = ADDR_W'({$urandom, $urandom});
                r.request_size = SIZE_W'($urandom);
                if (roll >= 67 && roll < 95 && live_off.size() != 0)
                begin
                    r.command = pscba_pkg::CMD_FREE;
                    pick = $urandom_range(0, live_off.size() - 1);
                    r.free_address = pool_base + live_off[pick];
                    // Most frees retire the buffer; a few free it twice.
                    if (roll < 92)
                        live_off.delete(pick);
                end
                else if (roll >= 95)
                begin
                    r.command = pscba_pkg::CMD_FREE;
                    if (roll >= 98 && live_off.size() != 0)
                        r.free_address = pool_base +
                            live_off[$urandom_range(0, live_off.size() - 1)] +
                            ADDR_W'($urandom_range(1, 31));
                end
                else
                begin
                    r.command = pscba_pkg::CMD_ALLOC;
                    if (roll < 55 || roll >= 67)
                        r.request_size = SIZE_W'($urandom_range(0, 2040));
                    else if (roll < 62)
                        r.request_size = SIZE_W'($urandom_range(0, 65528));
                    else if (roll < 64)
                        r.request_size = SIZE_W'($urandom_range(65529, 4194296));
                    else
                        r.request_size = SIZE_W'($urandom_range(4194297, 134217720));
                end
                issue(r, gap, 1'b0, none);
                if (live_off.size() > 400)
                    live_off.delete(0);
            end
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
